// ===== hdl/lcal_pkg.sv =====
// ----------------------------------------------------------------------------
// lcal_pkg
// Shared types, constants and address helpers for the common ancestor core.
// ----------------------------------------------------------------------------
package lcal_pkg;

    localparam int MAX_NODES = 4096;
    localparam int LEVELS    = 12;
    localparam int NODE_W    = 13;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_DEPTH = LEVELS * MAX_NODES;
    localparam int ANC_AW    = $clog2(ANC_DEPTH);
    localparam int DEP_W     = LEVELS;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        B_ROOT,
        B_FIX_RD,
        B_FIX_WR,
        B_LVL_RD1,
        B_LVL_RD2,
        B_LVL_WR,
        B_DEP_RD,
        B_DEP_UP,
        Q_DA,
        Q_DB,
        Q_SW,
        Q_LIFT,
        Q_LIFT_UP,
        Q_CMP,
        Q_RA,
        Q_RB,
        Q_RC,
        Q_FIN,
        Q_FIN2,
        Q_DONE
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [ANC_AW-1:0]     waddr;
        logic [NODE_W-1:0]     wdata;
        logic [ANC_AW-1:0]     raddr;
    } anc_req_t;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [DEP_W-1:0]      wdata;
        logic [IDX_W-1:0]      raddr;
    } dep_req_t;

    typedef struct packed {
        logic                  valid;
        logic [NODE_W-1:0]     ancestor;
        logic                  status;
    } res_t;

    function automatic logic [IDX_W-1:0] node_idx(logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] m;
        m = node - NODE_W'(1);
        return m[IDX_W-1:0];
    endfunction

    function automatic logic [ANC_AW-1:0] anc_addr(logic [NODE_W-1:0] node,
                                                   logic [LVL_W-1:0] lvl);
        return (ANC_AW'(lvl) << IDX_W) | ANC_AW'(node_idx(node));
    endfunction

endpackage

// ===== hdl/lcal_ram.sv =====
// ----------------------------------------------------------------------------
// lcal_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module lcal_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/lcal_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcal_ctrl
// Sequencer for load, table build and lifting query over the two RAMs.
// ----------------------------------------------------------------------------
module lcal_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lcal_pkg::NODE_W-1:0] n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lcal_pkg::op_t               op,
    input  logic [lcal_pkg::NODE_W-1:0] first_node,
    input  logic [lcal_pkg::NODE_W-1:0] second_node,
    output lcal_pkg::anc_req_t          anc_req,
    input  logic [lcal_pkg::NODE_W-1:0] anc_q,
    output lcal_pkg::dep_req_t          dep_req,
    input  logic [lcal_pkg::DEP_W-1:0]  dep_q,
    output lcal_pkg::res_t              res,
    input  logic                        out_free
);
    import lcal_pkg::*;

    localparam logic [LVL_W-1:0] K_TOP = LVL_W'(LEVELS - 1);

    state_t              state_reg, state_next;
    logic [NODE_W-1:0]   a_reg, a_next, b_reg, b_next, v_reg, v_next;
    logic [NODE_W-1:0]   ua_reg, ua_next, ans_reg, ans_next;
    logic [LVL_W-1:0]    k_reg, k_next;
    logic [DEP_W-1:0]    d_reg, d_next, diff_reg, diff_next, da_reg, da_next;
    logic                stat_reg, stat_next, zero_reg, zero_next;
    logic [NODE_W-1:0]   rdv, rd_node;
    logic [LVL_W-1:0]    rd_lvl;
    logic                accept, q_bad;

    assign rdv      = zero_reg ? '0 : anc_q;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign q_bad    = (first_node == '0) || (first_node > n) ||
                      (second_node == '0) || (second_node > n);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && op == OP_BUILD) begin
                    state_next = B_ROOT;
                end else if (accept && op == OP_QUERY) begin
                    state_next = q_bad ? Q_DONE : Q_DA;
                end
            end
            B_ROOT:    state_next = (n < NODE_W'(2)) ? B_LVL_RD1 : B_FIX_RD;
            B_FIX_RD:  state_next = B_FIX_WR;
            B_FIX_WR:  state_next = (v_reg == n) ? B_LVL_RD1 : B_FIX_RD;
            B_LVL_RD1: begin
                if (LEVELS == 1) begin
                    state_next = B_DEP_RD;
                end else begin
                    state_next = B_LVL_RD2;
                end
            end
            B_LVL_RD2: begin
                if (rdv != '0) begin
                    state_next = B_LVL_WR;
                end else if (v_reg == n && k_reg == K_TOP) begin
                    state_next = B_DEP_RD;
                end else begin
                    state_next = B_LVL_RD1;
                end
            end
            B_LVL_WR:  state_next = (v_reg == n && k_reg == K_TOP) ? B_DEP_RD : B_LVL_RD1;
            B_DEP_RD:  state_next = B_DEP_UP;
            B_DEP_UP:  state_next = (k_reg == '0 && v_reg == n) ? S_IDLE : B_DEP_RD;
            Q_DA:      state_next = Q_DB;
            Q_DB:      state_next = Q_SW;
            Q_SW:      state_next = Q_LIFT;
            Q_LIFT: begin
                if (diff_reg[k_reg]) begin
                    state_next = Q_LIFT_UP;
                end else if (k_reg == K_TOP) begin
                    state_next = Q_CMP;
                end
            end
            Q_LIFT_UP: state_next = (k_reg == K_TOP) ? Q_CMP : Q_LIFT;
            Q_CMP:     state_next = (a_reg == b_reg) ? Q_DONE : Q_RA;
            Q_RA:      state_next = Q_RB;
            Q_RB:      state_next = Q_RC;
            Q_RC:      state_next = (k_reg == '0) ? Q_FIN : Q_RA;
            Q_FIN:     state_next = Q_FIN2;
            Q_FIN2:    state_next = Q_DONE;
            Q_DONE:    state_next = out_free ? S_IDLE : Q_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        a_next = a_reg; b_next = b_reg; v_next = v_reg; ua_next = ua_reg;
        ans_next = ans_reg; k_next = k_reg; d_next = d_reg; diff_next = diff_reg;
        da_next = da_reg; stat_next = stat_reg;
        rd_node = a_reg; rd_lvl = k_reg;
        anc_req = '0;
        dep_req = '0;
        res = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept && op == OP_LOAD && first_node >= NODE_W'(2) &&
                    first_node <= n) begin
                    anc_req.we    = 1'b1;
                    anc_req.waddr = anc_addr(first_node, '0);
                    anc_req.wdata = (second_node <= NODE_W'(MAX_NODES)) ? second_node : '0;
                end
                a_next    = first_node;
                b_next    = second_node;
                stat_next = q_bad;
                ans_next  = '0;
            end
            B_ROOT: begin
                anc_req.we    = 1'b1;
                anc_req.waddr = anc_addr(NODE_W'(1), '0);
                anc_req.wdata = '0;
                v_next = (n < NODE_W'(2)) ? NODE_W'(1) : NODE_W'(2);
                k_next = LVL_W'(1);
            end
            B_FIX_RD: begin
                rd_node = v_reg;
                rd_lvl  = '0;
            end
            B_FIX_WR: begin
                if (rdv > n) begin
                    anc_req.we    = 1'b1;
                    anc_req.waddr = anc_addr(v_reg, '0);
                end
                v_next = (v_reg == n) ? NODE_W'(1) : v_reg + NODE_W'(1);
            end
            B_LVL_RD1: begin
                rd_node = v_reg;
                rd_lvl  = k_reg - LVL_W'(1);
                if (LEVELS == 1) begin
                    a_next = NODE_W'(1);
                    d_next = '0;
                    k_next = K_TOP;
                end
            end
            B_LVL_RD2: begin
                rd_node = rdv;
                rd_lvl  = k_reg - LVL_W'(1);
                if (rdv == '0) begin
                    anc_req.we    = 1'b1;
                    anc_req.waddr = anc_addr(v_reg, k_reg);
                    if (v_reg == n) begin
                        v_next = NODE_W'(1);
                        a_next = NODE_W'(1);
                        d_next = '0;
                        k_next = (k_reg == K_TOP) ? K_TOP : k_reg + LVL_W'(1);
                    end else begin
                        v_next = v_reg + NODE_W'(1);
                    end
                end
            end
            B_LVL_WR: begin
                anc_req.we    = 1'b1;
                anc_req.waddr = anc_addr(v_reg, k_reg);
                anc_req.wdata = rdv;
                if (v_reg == n) begin
                    v_next = NODE_W'(1);
                    a_next = NODE_W'(1);
                    d_next = '0;
                    k_next = (k_reg == K_TOP) ? K_TOP : k_reg + LVL_W'(1);
                end else begin
                    v_next = v_reg + NODE_W'(1);
                end
            end
            B_DEP_RD: begin
                rd_node = a_reg;
                rd_lvl  = k_reg;
            end
            B_DEP_UP: begin
                d_next = d_reg;
                if (rdv != '0) begin
                    d_next = d_reg | (DEP_W'(1) << k_reg);
                    a_next = rdv;
                end
                if (k_reg == '0) begin
                    dep_req.we    = 1'b1;
                    dep_req.waddr = node_idx(v_reg);
                    dep_req.wdata = d_next;
                    v_next = v_reg + NODE_W'(1);
                    a_next = v_reg + NODE_W'(1);
                    d_next = '0;
                    k_next = K_TOP;
                end else begin
                    k_next = k_reg - LVL_W'(1);
                end
            end
            Q_DA: begin
                dep_req.raddr = node_idx(a_reg);
            end
            Q_DB: begin
                da_next       = dep_q;
                dep_req.raddr = node_idx(b_reg);
            end
            Q_SW: begin
                if (da_reg < dep_q) begin
                    a_next    = b_reg;
                    b_next    = a_reg;
                    diff_next = dep_q - da_reg;
                end else begin
                    diff_next = da_reg - dep_q;
                end
                k_next = '0;
            end
            Q_LIFT: begin
                rd_node = a_reg;
                rd_lvl  = k_reg;
                if (!diff_reg[k_reg] && k_reg != K_TOP) begin
                    k_next = k_reg + LVL_W'(1);
                end
            end
            Q_LIFT_UP: begin
                a_next = rdv;
                if (k_reg != K_TOP) begin
                    k_next = k_reg + LVL_W'(1);
                end
            end
            Q_CMP: begin
                ans_next = a_reg;
                k_next   = K_TOP;
            end
            Q_RA: begin
                rd_node = a_reg;
                rd_lvl  = k_reg;
            end
            Q_RB: begin
                ua_next = rdv;
                rd_node = b_reg;
                rd_lvl  = k_reg;
            end
            Q_RC: begin
                if (ua_reg != rdv) begin
                    a_next = ua_reg;
                    b_next = rdv;
                end
                if (k_reg != '0) begin
                    k_next = k_reg - LVL_W'(1);
                end
            end
            Q_FIN: begin
                rd_node = a_reg;
                rd_lvl  = '0;
            end
            Q_FIN2: begin
                ans_next = rdv;
            end
            Q_DONE: begin
                res.valid    = 1'b1;
                res.ancestor = ans_reg;
                res.status   = stat_reg;
            end
            default: begin
            end
        endcase
        anc_req.raddr = anc_addr(rd_node, rd_lvl);
        zero_next     = (rd_node == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        v_reg    <= v_next;
        ua_reg   <= ua_next;
        ans_reg  <= ans_next;
        k_reg    <= k_next;
        d_reg    <= d_next;
        diff_reg <= diff_next;
        da_reg   <= da_next;
        stat_reg <= stat_next;
        zero_reg <= zero_next;
    end

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        anc_req.we && state_reg == B_LVL_RD2 |-> anc_req.waddr != anc_req.raddr)
        else $error("ancestor write collides with read");
    a_dep_wr_build: assert property (@(posedge aclk) disable iff (!aresetn)
        dep_req.we |-> state_reg == B_DEP_UP && k_reg == '0)
        else $error("depth write outside build");
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && !out_free |=> res.valid && $stable(res.ancestor))
        else $error("result dropped before taken");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.status |-> res.ancestor == '0)
        else $error("error result with nonzero ancestor");

endmodule

// ===== hdl/lowest_common_ancestor_lifting_core.sv =====
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting_core
// Lowest common ancestor by binary lifting over a parent-loaded rooted tree.
// ----------------------------------------------------------------------------
// A load request writes one parent entry from the idle state. A build request
// runs through the ancestor RAM: a read and a possible write per node for the
// parent fix-up, two reads and a write per node for each of the LEVELS-1
// ancestor levels, and a read per node and level for the depths, with one depth
// write per node. A query reads both depths, walks every level of the depth
// difference and lifts on each set bit, compares and, unless the nodes already
// meet, lifts both nodes level by level from the top and reads the final
// parent; a last state hands the result to the output register. The next
// request is taken in the idle state. Out-of-range queries go straight to the
// result and answer with status 1.
// Results queue in one output register; while it is full, a finished query
// holds the core until the receiver takes the waiting result.
module lowest_common_ancestor_lifting_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [12:0] first_node, [25:13] second_node
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [12:0] ancestor
    output logic        m_tuser    // [0] status
);
    import lcal_pkg::*;

    logic [NODE_W-1:0] node_count_reg, n;
    anc_req_t          anc_req;
    dep_req_t          dep_req;
    res_t              res;
    logic [NODE_W-1:0] anc_q;
    logic [DEP_W-1:0]  dep_q;
    logic              m_tvalid_reg, out_free;
    logic [NODE_W-1:0] m_anc_reg;
    logic              m_stat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_W'(1);
        end else if (cfg_we) begin
            node_count_reg <= cfg_wdata;
        end
    end

    assign n = (node_count_reg == '0) ? NODE_W'(1) :
               (node_count_reg > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    lcal_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .n           (n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .op          (op_t'(s_tuser)),
        .first_node  (s_tdata[12:0]),
        .second_node (s_tdata[25:13]),
        .anc_req     (anc_req),
        .anc_q       (anc_q),
        .dep_req     (dep_req),
        .dep_q       (dep_q),
        .res         (res),
        .out_free    (out_free)
    );

    lcal_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
        .aclk  (aclk),
        .we    (anc_req.we),
        .waddr (anc_req.waddr),
        .wdata (anc_req.wdata),
        .raddr (anc_req.raddr),
        .rdata (anc_q)
    );

    lcal_ram #(.WIDTH(DEP_W), .DEPTH(MAX_NODES)) u_dep_ram (
        .aclk  (aclk),
        .we    (dep_req.we),
        .waddr (dep_req.waddr),
        .wdata (dep_req.wdata),
        .raddr (dep_req.raddr),
        .rdata (dep_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res.valid && out_free) begin
            m_anc_reg  <= res.ancestor;
            m_stat_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_anc_reg};
    assign m_tuser  = m_stat_reg;

endmodule
